@@ rtl/rfa_pkg.sv @@
// Shared types, constants and handshake structs of the region flow averager.
package rfa_pkg;

  localparam int FLOW_W     = 16;  // flow component width, signed Q8.8
  localparam int COORD_W    = 16;  // rectangle center, signed Q12.4
  localparam int SIZE_W     = 15;  // rectangle size, unsigned Q11.4
  localparam int DIMREG_W   = 11;  // image dimension registers
  localparam int COUNT_W    = 20;  // inside pixel count
  localparam int CFG_W      = 16;  // widest configuration register
  localparam int CFG_ADDR_W = 3;
  localparam int BND_W      = 14;  // signed pixel bounds
  localparam int FRAC_SHIFT = 5;   // doubled Q12.4 values carry five fraction bits

  localparam logic [DIMREG_W-1:0] DIM_RESET = DIMREG_W'(1024);
  localparam logic [COUNT_W-1:0]  COUNT_MAX = '1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_WIDTH    = 3'd2,
    REG_HEIGHT   = 3'd3,
    REG_COLS     = 3'd4,
    REG_ROWS     = 3'd5
  } rfa_reg_e;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_START_X,
    ST_DIV_X,
    ST_DIV_Y,
    ST_EMIT
  } rfa_state_e;

  typedef struct packed {
    logic signed [FLOW_W-1:0] flow_x;
    logic signed [FLOW_W-1:0] flow_y;
    logic                     frame_last;
  } rfa_pix_t;

  typedef struct packed {
    logic signed [FLOW_W-1:0] mean_x;
    logic signed [FLOW_W-1:0] mean_y;
    logic [COUNT_W-1:0]       pixel_count;
    logic                     region_empty;
  } rfa_res_t;

  typedef struct packed {
    logic pix_acc;
    logic div_start;
    logic div_sel_y;
    logic cap_x;
    logic load_out;
  } rfa_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic empty;
  } rfa_sts_t;

endpackage

@@ rtl/rfa_divider.sv @@
// Serial restoring divider: signed sum over unsigned count, truncated toward zero.
module rfa_divider import rfa_pkg::*; #(
  parameter int DVD_W = 36
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [DVD_W-1:0]  dividend_i,
  input  logic [COUNT_W-1:0]       divisor_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic signed [FLOW_W-1:0] quot_o
);

  localparam int STEP_W = $clog2(DVD_W);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               neg_q, neg_d;
  logic [DVD_W-1:0]   dvd_q, dvd_d;
  logic [COUNT_W-1:0] rem_q, rem_d;
  logic [COUNT_W-1:0] dsr_q, dsr_d;

  logic [COUNT_W:0]   trial;
  logic [COUNT_W+1:0] diff;
  logic               ge;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dsr_q};
  assign ge    = ~diff[COUNT_W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    step_d = step_q;
    neg_d  = neg_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      step_d = '0;
      neg_d  = dividend_i[DVD_W-1];
      // The negation of the most negative sum still reads right as unsigned.
      dvd_d  = dividend_i[DVD_W-1] ? DVD_W'(-dividend_i) : DVD_W'(dividend_i);
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
      dvd_d = {dvd_q[DVD_W-2:0], ge};
      if (step_q == STEP_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(dvd_q[FLOW_W-1:0]) : $signed(dvd_q[FLOW_W-1:0]);

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while a division is running");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(busy_q))
    else $error("divider finished without running");

endmodule

@@ rtl/rfa_datapath.sv @@
// Datapath: configuration, position counters, region test, sums, divider and result register.
module rfa_datapath import rfa_pkg::*; #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  rfa_pix_t              pix_i,
  input  rfa_cmd_t              cmd_i,
  output rfa_sts_t              sts_o,
  output rfa_res_t              res_o
);

  localparam int CW     = $clog2(MAX_COLS);
  localparam int RW     = $clog2(MAX_ROWS);
  localparam int CDIM_W = ($clog2(MAX_COLS + 1) > DIMREG_W) ? $clog2(MAX_COLS + 1) : DIMREG_W;
  localparam int RDIM_W = ($clog2(MAX_ROWS + 1) > DIMREG_W) ? $clog2(MAX_ROWS + 1) : DIMREG_W;
  localparam int SUM_W  = FLOW_W + CW + RW;

  // Floor of (2 * center - size) / 32, never below column or row zero.
  function automatic logic signed [BND_W-1:0] lo_bound(
    input logic signed [COORD_W-1:0] c,
    input logic [SIZE_W-1:0]         s
  );
    logic signed [COORD_W+1:0] a;
    logic signed [COORD_W+1:0] f;
    a = $signed({c[COORD_W-1], c, 1'b0}) - $signed({{(COORD_W+2-SIZE_W){1'b0}}, s});
    f = a >>> FRAC_SHIFT;
    if (f < 0) begin
      return '0;
    end
    return BND_W'(f);
  endfunction

  // Ceiling of (2 * center + size) / 32, never above the last index.
  function automatic logic signed [BND_W-1:0] hi_bound(
    input logic signed [COORD_W-1:0] c,
    input logic [SIZE_W-1:0]         s,
    input logic signed [BND_W-1:0]   dmax
  );
    logic signed [COORD_W+1:0] b;
    logic signed [COORD_W+1:0] f;
    b = $signed({c[COORD_W-1], c, 1'b0}) + $signed({{(COORD_W+2-SIZE_W){1'b0}}, s})
        + $signed((COORD_W+2)'((1 << FRAC_SHIFT) - 1));
    f = b >>> FRAC_SHIFT;
    if (f > dmax) begin
      return dmax;
    end
    return BND_W'(f);
  endfunction

  logic signed [COORD_W-1:0] center_x_q, center_y_q;
  logic [SIZE_W-1:0]         width_q, height_q;
  logic [DIMREG_W-1:0]       cols_q, rows_q;

  logic [CW-1:0]             col_q, col_d;
  logic [RW-1:0]             row_q, row_d;
  logic signed [SUM_W-1:0]   sum_x_q, sum_x_d;
  logic signed [SUM_W-1:0]   sum_y_q, sum_y_d;
  logic [COUNT_W-1:0]        count_q, count_d;
  logic signed [FLOW_W-1:0]  mean_x_q;
  rfa_res_t                  res_q;

  logic [CDIM_W-1:0]         cols_eff;
  logic [RDIM_W-1:0]         rows_eff;
  logic signed [BND_W-1:0]   xlo, xhi, ylo, yhi;
  logic signed [BND_W-1:0]   col_s, row_s;
  logic                      in_region;
  logic                      empty;
  logic                      div_busy, div_done;
  logic signed [FLOW_W-1:0]  quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      width_q    <= '0;
      height_q   <= '0;
      cols_q     <= DIM_RESET;
      rows_q     <= DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (rfa_reg_e'(cfg_addr_i))
        REG_CENTER_X: center_x_q <= $signed(cfg_wdata_i[COORD_W-1:0]);
        REG_CENTER_Y: center_y_q <= $signed(cfg_wdata_i[COORD_W-1:0]);
        REG_WIDTH:    width_q    <= cfg_wdata_i[SIZE_W-1:0];
        REG_HEIGHT:   height_q   <= cfg_wdata_i[SIZE_W-1:0];
        REG_COLS:     cols_q     <= cfg_wdata_i[DIMREG_W-1:0];
        REG_ROWS:     rows_q     <= cfg_wdata_i[DIMREG_W-1:0];
        default: ;
      endcase
    end
  end

  // A dimension of zero or beyond the build maximum falls back to the maximum.
  always_comb begin
    cols_eff = CDIM_W'(cols_q);
    if (cols_eff == '0 || cols_eff > CDIM_W'(MAX_COLS)) begin
      cols_eff = CDIM_W'(MAX_COLS);
    end
    rows_eff = RDIM_W'(rows_q);
    if (rows_eff == '0 || rows_eff > RDIM_W'(MAX_ROWS)) begin
      rows_eff = RDIM_W'(MAX_ROWS);
    end
  end

  assign xlo   = lo_bound(center_x_q, width_q);
  assign ylo   = lo_bound(center_y_q, height_q);
  assign xhi   = hi_bound(center_x_q, width_q, $signed(BND_W'(cols_eff - CDIM_W'(1))));
  assign yhi   = hi_bound(center_y_q, height_q, $signed(BND_W'(rows_eff - RDIM_W'(1))));
  assign col_s = $signed(BND_W'(col_q));
  assign row_s = $signed(BND_W'(row_q));
  // Upper bounds are exclusive, so a negative upper bound leaves the axis empty.
  assign in_region = (col_s >= xlo) && (col_s < xhi) && (row_s >= ylo) && (row_s < yhi);
  assign empty     = (count_q == '0);

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    sum_x_d = sum_x_q;
    sum_y_d = sum_y_q;
    count_d = count_q;
    if (cmd_i.load_out) begin
      col_d   = '0;
      row_d   = '0;
      sum_x_d = '0;
      sum_y_d = '0;
      count_d = '0;
    end else if (cmd_i.pix_acc) begin
      if (in_region) begin
        sum_x_d = sum_x_q + SUM_W'(pix_i.flow_x);
        sum_y_d = sum_y_q + SUM_W'(pix_i.flow_y);
        if (count_q != COUNT_MAX) begin
          count_d = count_q + COUNT_W'(1);
        end
      end
      if (!pix_i.frame_last) begin
        if (CDIM_W'(col_q) + CDIM_W'(1) >= cols_eff) begin
          col_d = '0;
          if (RDIM_W'(row_q) + RDIM_W'(1) >= rows_eff) begin
            row_d = '0;
          end else begin
            row_d = row_q + RW'(1);
          end
        end else begin
          col_d = col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      sum_x_q <= '0;
      sum_y_q <= '0;
      count_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
      count_q <= count_d;
    end
  end

  rfa_divider #(
    .DVD_W(SUM_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (cmd_i.div_sel_y ? sum_y_q : sum_x_q),
    .divisor_i  (count_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_x) begin
      mean_x_q <= quot;
    end
    if (cmd_i.load_out) begin
      res_q.mean_x       <= empty ? '0 : mean_x_q;
      res_q.mean_y       <= empty ? '0 : quot;
      res_q.pixel_count  <= count_q;
      res_q.region_empty <= empty;
    end
  end

  assign sts_o.div_busy = div_busy;
  assign sts_o.div_done = div_done;
  assign sts_o.empty    = empty;
  assign res_o          = res_q;

  a_count_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == COUNT_MAX && !cmd_i.load_out) |=> count_q == COUNT_MAX)
    else $error("inside count wrapped past its maximum");

endmodule

@@ rtl/rfa_ctrl.sv @@
// Controller: frame sequencing, division order and result register handshake.
module rfa_ctrl import rfa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     frame_last_i,
  input  logic     out_ready_i,
  input  rfa_sts_t sts_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  output rfa_cmd_t cmd_o
);

  rfa_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_ACCUM: begin
        in_ready_o    = 1'b1;
        cmd_o.pix_acc = in_valid_i;
        if (in_valid_i && frame_last_i) begin
          state_d = ST_START_X;
        end
      end
      ST_START_X: begin
        if (sts_i.empty) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV_X;
        end
      end
      ST_DIV_X: begin
        if (sts_i.div_done) begin
          cmd_o.cap_x     = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel_y = 1'b1;
          state_d         = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        if (sts_i.div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // The previous result must be transferred before it is replaced.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_ACCUM;
        end
      end
      default: state_d = ST_ACCUM;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCUM;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_idle_divider: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ACCUM |-> !sts_i.div_busy)
    else $error("divider still running while pixels are accepted");

endmodule

@@ rtl/roi_flow_average.sv @@
// Top level of the region-of-interest mean flow block.
//
// Pixels of a flow field are taken in raster order at one per cycle while the block
// accumulates; column and row positions come from internal counters, and pixels inside
// the configured rectangle are summed and counted. The transfer of a pixel flagged as
// frame last closes the frame: the two means are then formed one after the other in a
// shared bit-serial restoring divider of SUM_W = 16 + log2(MAX_COLS) + log2(MAX_ROWS)
// bits, so the input stalls after that pixel while both divisions run, or only through
// the count check and the result load when the region is empty. The result sits in an
// output register, and the next frame's pixels are taken while it waits; a frame end
// that finds the previous result still untaken holds until that result is transferred.
// Configuration writes take effect at once and are meant for idle periods.
module roi_flow_average import rfa_pkg::*; #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rfa_pix_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rfa_res_t              out_data_o
);

  rfa_cmd_t cmd;
  rfa_sts_t sts;

  rfa_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .frame_last_i (in_data_i.frame_last),
    .out_ready_i  (out_ready_i),
    .sts_i        (sts),
    .in_ready_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .cmd_o        (cmd)
  );

  rfa_datapath #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (out_data_o)
  );

endmodule
